// ===== rtl/core/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared codes and types for the console line editor receive path.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ECHO   = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW   = 8'h2B;
  localparam logic [7:0] CH_HIGH  = 8'h7B;

  localparam int LEN_W = 5;

  // Which set of results an accepted request produces.
  typedef enum logic [3:0] {
    RES_STATUS = 4'b0001,
    RES_CR     = 4'b0010,
    RES_ERASE  = 4'b0100,
    RES_READ   = 4'b1000
  } res_cls_t;

endpackage

// ===== rtl/core/cle_if.sv =====
// ----------------------------------------------------------------------------
// cle_if
// Request and result channels of the console line editor.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  logic       framing_error;
  logic       overrun_error;
  logic [4:0] read_index;

  modport source (output valid, opcode, rx_byte, framing_error, overrun_error, read_index,
                  input ready);
  modport sink (input valid, opcode, rx_byte, framing_error, overrun_error, read_index,
                output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       line_complete;
  logic [4:0] command_length;
  logic       last;

  modport source (output valid, kind, data_byte, line_complete, command_length, last,
                  input ready);
  modport sink (input valid, kind, data_byte, line_complete, command_length, last,
                output ready);
endinterface

// ===== rtl/core/console_line_editor_rx.sv =====
// ----------------------------------------------------------------------------
// console_line_editor_rx
// Edits received console bytes into a command line held in a line memory.
// ----------------------------------------------------------------------------
// A request is taken every cycle while the result side keeps up; each request
// gives one result, except an erase of a character, which gives three echo
// results (BS, space, BS) in order, and no new request is taken until the last
// of them leaves the result stage. The line is kept in a memory of LINE_DEPTH
// bytes with a registered read port; the edit and the memory write happen in
// the cycle the request is taken, as does the read of the port. Entries not
// yet written since reset read as zero through a valid bit per entry, so no
// clearing pass is needed.
module console_line_editor_rx
  import cle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cle_in_if.sink     in_item,
  cle_out_if.source  out_item
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(LINE_DEPTH - 1);

  logic [7:0]          line_mem_r [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] vld_r;
  logic [7:0]          rd_data_r;
  logic                rd_ok_r;

  logic [AW-1:0]       wp_r, wp_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;

  logic                s1_valid_r;
  res_cls_t            s1_cls_r, cls_nxt;
  logic [1:0]          s1_step_r;
  logic                s1_pend_r;
  logic [LEN_W-1:0]    s1_len_r;

  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [7:0]          out_data_r;
  logic                out_pend_r;
  logic [LEN_W-1:0]    out_len_r;
  logic                out_last_r;

  logic                we;
  logic [7:0]          wdata;
  logic [AW-1:0]       rd_addr;
  logic                rd_in_range;
  logic                accept;
  logic                s1_move;
  logic                s1_done;
  logic [1:0]          res_kind;
  logic [7:0]          res_data;
  logic                res_last;
  logic [7:0]          c;

  assign c           = in_item.rx_byte;
  assign rd_addr     = AW'(in_item.read_index);
  assign rd_in_range = 32'(in_item.read_index) < LINE_DEPTH;

  assign s1_move = s1_valid_r && (!out_valid_r || out_item.ready);
  assign s1_done = s1_move && ((s1_cls_r != RES_ERASE) || (s1_step_r == 2'd2));
  assign in_item.ready = !s1_valid_r || s1_done;
  assign accept = in_item.valid && in_item.ready;

  always_comb begin
    wp_nxt   = wp_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    cls_nxt  = RES_STATUS;
    we       = 1'b0;
    wdata    = c;
    unique case (in_item.opcode)
      OP_RX_BYTE: begin
        if (in_item.framing_error || in_item.overrun_error || pend_r) begin
          cls_nxt = RES_STATUS;
        end else if (wp_r >= LAST_POS) begin
          we       = 1'b1;
          wdata    = 8'h00;
          wp_nxt   = '0;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
        end else begin
          we = 1'b1;
          priority if (c == CH_LF || c == CH_CR) begin
            wdata    = 8'h00;
            pend_nxt = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
            wp_nxt   = '0;
          end else if (c == CH_BS || c == CH_DEL) begin
            if (wp_r != '0) begin
              wp_nxt  = wp_r - 1'b1;
              cnt_nxt = cnt_r - 1'b1;
              cls_nxt = RES_ERASE;
            end
          end else if (c > CH_LOW && c < CH_HIGH) begin
            wp_nxt  = wp_r + 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else if (c == CH_ESC) begin
            wp_nxt  = '0;
            cnt_nxt = '0;
            cls_nxt = RES_CR;
          end else begin
            cls_nxt = RES_STATUS;
          end
        end
      end
      OP_RELEASE: begin
        pend_nxt = 1'b0;
        wp_nxt   = '0;
        cnt_nxt  = '0;
      end
      OP_READ: begin
        cls_nxt = RES_READ;
      end
      default: begin
        cls_nxt = RES_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && we) begin
      line_mem_r[wp_r] <= wdata;
    end
    if (accept) begin
      rd_data_r <= line_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
      wp_r    <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else if (accept) begin
      if (we) begin
        vld_r[wp_r] <= 1'b1;
      end
      rd_ok_r <= rd_in_range && vld_r[rd_addr];
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_cls_r   <= RES_STATUS;
      s1_step_r  <= '0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      s1_cls_r   <= cls_nxt;
      s1_step_r  <= '0;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end else if (s1_move) begin
      s1_step_r <= s1_step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pend_r <= pend_nxt;
      s1_len_r  <= cnt_nxt;
    end
  end

  always_comb begin
    res_kind = KIND_STATUS;
    res_data = 8'h00;
    res_last = 1'b1;
    unique case (s1_cls_r)
      RES_STATUS: begin
        res_kind = KIND_STATUS;
      end
      RES_CR: begin
        res_kind = KIND_ECHO;
        res_data = CH_CR;
      end
      RES_ERASE: begin
        res_kind = KIND_ECHO;
        res_data = (s1_step_r == 2'd1) ? CH_SPACE : CH_BS;
        res_last = (s1_step_r == 2'd2);
      end
      RES_READ: begin
        res_kind = KIND_READ;
        res_data = rd_ok_r ? rd_data_r : 8'h00;
      end
      default: begin
        res_kind = KIND_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_pend_r <= s1_pend_r;
      out_len_r  <= s1_len_r;
      out_last_r <= res_last;
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.kind           = out_kind_r;
  assign out_item.data_byte      = out_data_r;
  assign out_item.line_complete  = out_pend_r;
  assign out_item.command_length = out_len_r;
  assign out_item.last           = out_last_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console line editor receive path. A directed
// table covers the byte classes, errors, a pending line, erase and release,
// then random command lines and noise follow. A line-editing predictor in the
// bench forms the expected results, and each result taken from the block is
// compared with the oldest one still awaited.
// ----------------------------------------------------------------------------
module tb_top;
  import cle_pkg::*;

  localparam int LINE_DEPTH      = 32;
  localparam int RANDOM_REQUESTS = 175;
  localparam int HOLD_CYCLES     = 150;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       overrun_error;
    logic [4:0] read_index;
    logic       typed;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       line_complete;
    logic [4:0] command_length;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       line_complete;
    logic [4:0] command_length;
    logic       last;
  } result_t;

  logic clk;
  logic rst_n;

  cle_in_if  in_if ();
  cle_out_if out_if ();

  console_line_editor_rx #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_if),
    .out_item(out_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic [7:0] line_mem [LINE_DEPTH];
  int         cursor;
  logic [7:0] char_total;
  logic       line_ready;

  request_t plan[$];
  result_t  awaited[$];
  int       mismatches;
  int       accepted_requests;
  int       hold_at;

  function automatic request_t row(input logic [1:0] op, input logic [7:0] b,
                                   input logic fe, input logic oe,
                                   input logic [4:0] idx, input logic typed,
                                   input logic [1:0] kind, input logic [7:0] data,
                                   input logic lc, input logic [4:0] len);
    request_t r;
    r = {op, b, fe, oe, idx, typed, kind, data, lc, len};
    return r;
  endfunction

  function automatic request_t plain(input logic [1:0] op, input logic [7:0] b,
                                     input logic fe, input logic oe,
                                     input logic [4:0] idx);
    return row(op, b, fe, oe, idx, 1'b0, KIND_STATUS, 8'h00, 1'b0, 5'd0);
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                             input logic last);
    awaited.push_back({kind, data, line_ready, char_total[4:0], last});
  endtask

  task automatic apply_request(input request_t r);
    logic err;
    err = r.framing_error | r.overrun_error;
    case (r.opcode)
      OP_RX_BYTE: begin
        if (err || line_ready) begin
          push_result(KIND_STATUS, 8'h00, 1'b1);
        end else if (cursor > LINE_DEPTH - 2) begin
          cursor = 0;
          line_mem[LINE_DEPTH - 1] = 8'h00;
          line_ready = 1'b0;
          char_total = 8'd0;
          push_result(KIND_STATUS, 8'h00, 1'b1);
        end else begin
          line_mem[cursor] = r.rx_byte;
          if (r.rx_byte == CH_CR || r.rx_byte == CH_LF) begin
            line_ready = 1'b1;
            char_total = char_total + 8'd1;
            line_mem[cursor] = 8'h00;
            cursor = 0;
            push_result(KIND_STATUS, 8'h00, 1'b1);
          end else if (r.rx_byte == CH_BS || r.rx_byte == CH_DEL) begin
            if (cursor > 0) begin
              cursor--;
              char_total = char_total - 8'd1;
              push_result(KIND_ECHO, CH_BS, 1'b0);
              push_result(KIND_ECHO, CH_SPACE, 1'b0);
              push_result(KIND_ECHO, CH_BS, 1'b1);
            end else begin
              push_result(KIND_STATUS, 8'h00, 1'b1);
            end
          end else if (r.rx_byte > CH_LOW && r.rx_byte < CH_HIGH) begin
            cursor++;
            char_total = char_total + 8'd1;
            push_result(KIND_STATUS, 8'h00, 1'b1);
          end else if (r.rx_byte == CH_ESC) begin
            cursor = 0;
            char_total = 8'd0;
            push_result(KIND_ECHO, CH_CR, 1'b1);
          end else begin
            push_result(KIND_STATUS, 8'h00, 1'b1);
          end
        end
      end
      OP_RELEASE: begin
        line_ready = 1'b0;
        cursor = 0;
        char_total = 8'd0;
        push_result(KIND_STATUS, 8'h00, 1'b1);
      end
      OP_READ: begin
        push_result(KIND_READ, line_mem[r.read_index], 1'b1);
      end
      default: begin
        push_result(KIND_STATUS, 8'h00, 1'b1);
      end
    endcase
  endtask

  task automatic add_line();
    int len;
    int k;
    int top;
    logic fe;
    logic oe;
    logic long_line;
    long_line = ($urandom_range(0, 9) == 0);
    len = long_line ? $urandom_range(28, 33) : $urandom_range(0, 10);
    for (k = 0; k < len; k++) begin
      case (long_line ? 19 : $urandom_range(0, 19))
        0, 1: plan.push_back(plain(OP_RX_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL,
                                   1'b0, 1'b0, 5'd0));
        2: begin
          fe = 1'($urandom_range(0, 1));
          oe = fe ? 1'($urandom_range(0, 1)) : 1'b1;
          plan.push_back(plain(OP_RX_BYTE, 8'($urandom_range(0, 255)), fe, oe, 5'd0));
        end
        3: plan.push_back(plain(OP_RX_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                                5'd0));
        4: plan.push_back(plain(OP_RX_BYTE, CH_ESC, 1'b0, 1'b0, 5'd0));
        default: plan.push_back(plain(OP_RX_BYTE, 8'($urandom_range(8'h2C, 8'h7A)),
                                      1'b0, 1'b0, 5'd0));
      endcase
    end
    plan.push_back(plain(OP_RX_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF,
                         1'b0, 1'b0, 5'd0));
    top = (len + 1 > 31) ? 31 : len + 1;
    for (k = $urandom_range(0, 3); k > 0; k--) begin
      plan.push_back(plain(OP_READ, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                           5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, top))));
    end
    if ($urandom_range(0, 5) != 0) begin
      plan.push_back(plain(OP_RELEASE, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 5'd0));
    end
  endtask

  task automatic add_noise();
    int k;
    for (k = $urandom_range(1, 4); k > 0; k--) begin
      plan.push_back(plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           5'($urandom_range(0, 31))));
    end
  endtask

  initial begin : stimulus
    request_t cur;
    int       burst_left;
    int       n_directed;
    int       i;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_RX_BYTE;
    in_if.rx_byte = 8'h00;
    in_if.framing_error = 1'b0;
    in_if.overrun_error = 1'b0;
    in_if.read_index = 5'd0;
    mismatches = 0;
    accepted_requests = 0;
    hold_at = 1 << 30;
    for (i = 0; i < LINE_DEPTH; i++) begin
      line_mem[i] = 8'h00;
    end
    cursor = 0;
    char_total = 8'd0;
    line_ready = 1'b0;

    plan.push_back(row(OP_READ, 8'h00, 0, 0, 5'd0, 1, KIND_READ, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_READ, 8'h00, 0, 0, 5'd31, 1, KIND_READ, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_RX_BYTE, 8'h41, 1, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_RX_BYTE, 8'h41, 0, 1, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_RX_BYTE, 8'h41, 1, 1, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_RX_BYTE, CH_BS, 0, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_READ, 8'h00, 0, 0, 5'd0, 1, KIND_READ, CH_BS, 0, 5'd0));
    plan.push_back(row(OP_RX_BYTE, CH_LOW, 0, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_RX_BYTE, CH_HIGH, 0, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd0));
    plan.push_back(row(OP_RX_BYTE, 8'h2C, 0, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd1));
    plan.push_back(row(OP_RX_BYTE, 8'h7A, 0, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd2));
    plan.push_back(row(OP_RX_BYTE, 8'hFF, 0, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd2));
    plan.push_back(row(OP_RX_BYTE, 8'h00, 0, 0, 5'd0, 1, KIND_STATUS, 8'h00, 0, 5'd2));
    plan.push_back(plain(OP_RX_BYTE, CH_BS, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, CH_DEL, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, 8'h61, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, CH_ESC, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, 8'h71, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, CH_LF, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, 8'h78, 0, 0, 5'd0));
    plan.push_back(plain(OP_RELEASE, 8'h00, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, 8'h6B, 0, 0, 5'd0));
    plan.push_back(plain(OP_RX_BYTE, CH_CR, 0, 0, 5'd0));
    plan.push_back(plain(OP_READ, 8'h00, 0, 0, 5'd1));
    plan.push_back(plain(OP_NONE, 8'h00, 0, 0, 5'd0));
    n_directed = plan.size();
    hold_at = n_directed + 40;

    while (plan.size() < n_directed + RANDOM_REQUESTS) begin
      if ($urandom_range(0, 9) < 7) begin
        add_line();
      end else begin
        add_noise();
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    for (i = 0; i < plan.size(); i++) begin
      cur = plan[i];
      if (i == n_directed || i == n_directed + 120) begin
        in_if.valid <= 1'b0;
        do @(posedge clk); while (awaited.size() != 0);
      end else if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
      if (burst_left > 0) begin
        burst_left--;
      end
      in_if.opcode <= cur.opcode;
      in_if.rx_byte <= cur.rx_byte;
      in_if.framing_error <= cur.framing_error;
      in_if.overrun_error <= cur.overrun_error;
      in_if.read_index <= cur.read_index;
      in_if.valid <= 1'b1;
      do @(posedge clk); while (!in_if.ready);
      accepted_requests++;
      apply_request(cur);
      if (cur.typed) begin
        void'(awaited.pop_back());
        awaited.push_back({cur.kind, cur.data_byte, cur.line_complete,
                           cur.command_length, 1'b1});
      end
    end
    in_if.valid <= 1'b0;

    do @(posedge clk); while (awaited.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", awaited.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : receiver
    int  mode;
    int  left;
    int  phase;
    bit  hold_done;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    phase = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_requests >= hold_at) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      phase++;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (phase % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.kind, out_if.data_byte, out_if.line_complete,
             out_if.command_length, out_if.last};
      if (awaited.size() == 0) begin
        note_failure($sformatf("unexpected result kind=%0d data=%02h lc=%0d len=%0d last=%0d",
                               got.kind, got.data_byte, got.line_complete,
                               got.command_length, got.last));
      end else begin
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.line_complete !== want.line_complete ||
            got.command_length !== want.command_length || got.last !== want.last) begin
          note_failure($sformatf({"result differs: expected kind=%0d data=%02h lc=%0d ",
                                  "len=%0d last=%0d, got kind=%0d data=%02h lc=%0d ",
                                  "len=%0d last=%0d"},
                                 want.kind, want.data_byte, want.line_complete,
                                 want.command_length, want.last, got.kind,
                                 got.data_byte, got.line_complete,
                                 got.command_length, got.last));
        end
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
